/* hdl/rnrb_pkg.sv */
// Package for the RTP NACK retransmit buffer: payload structs and codes.
// Used by rnrb_ring and rtp_nack_retransmit_buffer; depends on nothing.
`default_nettype none
package rnrb_pkg;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_NACK  = 1'b1;

  localparam logic [2:0] CFG_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_RTX     = 3'd1;
  localparam logic [2:0] CFG_RTX_PT  = 3'd2;
  localparam logic [2:0] CFG_RTX_SSRC = 3'd3;
  localparam logic [2:0] CFG_SWAP    = 3'd4;
  localparam logic [2:0] CFG_HOLDOFF = 3'd5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Ring depth is a power of two so that slot indexes wrap by truncation.
  localparam int RING_DEPTH = 256;
  localparam int MASK_BITS  = 16;

  typedef struct packed {
    logic        opcode;
    logic [47:0] current_time;
    logic [15:0] sequence_number;
    logic [15:0] loss_bitmask;
    logic [6:0]  payload_type;
    logic [31:0] rtp_timestamp;
    logic [31:0] source_id;
    logic        marker_bit;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        last_item;
    logic [15:0] out_sequence;
    logic [6:0]  out_payload_type;
    logic [31:0] out_timestamp;
    logic [31:0] out_ssrc;
    logic        out_marker;
    logic [15:0] original_seq_prefix;
    logic [15:0] out_length;
    logic [4:0]  ignored_count;
    logic [4:0]  sent_count;
    logic [4:0]  not_found_count;
    logic [20:0] bytes_sent;
  } out_item_t;

  // One slot's descriptor as held in the ring memory.
  typedef struct packed {
    logic [15:0] seq;
    logic [6:0]  pt;
    logic [31:0] ts;
    logic [31:0] src;
    logic        marker;
    logic [15:0] len;
  } slot_t;

endpackage
`default_nettype wire

/* hdl/rnrb_ring.sv */
// Ring memory of packet descriptors and their last-sent times.
// One write port each, one registered read port; uses rnrb_pkg.
`default_nettype none
module rnrb_ring #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic                clk,
  input  wire logic                slot_we,
  input  wire logic [AW-1:0]       slot_waddr,
  input  wire rnrb_pkg::slot_t     slot_wdata,
  input  wire logic                time_we,
  input  wire logic [AW-1:0]       time_waddr,
  input  wire logic [47:0]         time_wdata,
  input  wire logic [AW-1:0]       raddr,
  output rnrb_pkg::slot_t          slot_rdata,
  output logic [47:0]              time_rdata
);
  import rnrb_pkg::*;

  slot_t       slot_mem [DEPTH];
  logic [47:0] time_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_waddr] <= time_wdata;
    end
    time_rdata <= time_mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/rtp_nack_retransmit_buffer.sv */
// Top level of the RTP NACK retransmit buffer: sequencer, shared compare unit.
// Depends on rnrb_pkg and rnrb_ring.
//
// Channel   Signals                       Transfer
// input     start, busy, in_item          start high and busy low at a clock edge
// result    result_valid, result          one cycle per result, cannot be held off
// config    cfg_we, cfg_index, cfg_data   cfg_we high at a clock edge
//
// A store keeps busy high while S_STORE writes the slot. A NACK on an empty
// ring goes straight to its summary. Otherwise it reads the oldest and newest
// slot and maps the PID, then walks the 16 mask bits in S_NEXT, visiting each
// flagged slot in range, the PID slot included, through S_WAIT, S_CHK_TIME and
// S_CHK_SEQ. Each result appears the cycle after the state that makes it.
// Reset is synchronous; ring contents are not cleared.
`default_nettype none
module rtp_nack_retransmit_buffer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire rnrb_pkg::in_item_t             in_item,
  output logic                                result_valid,
  output rnrb_pkg::out_item_t                 result,
  input  wire logic                           cfg_we,
  input  wire logic [rnrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rnrb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rnrb_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int MW = $clog2(MASK_BITS + 1);
  localparam int BW = $clog2(MASK_BITS);
  localparam int CW = 5;

  localparam logic [3:0] S_IDLE = 4'd0, S_STORE = 4'd1, S_RD_START = 4'd2,
    S_RD_END = 4'd3, S_WAIT_END = 4'd4, S_MAP = 4'd5, S_NEXT = 4'd6,
    S_RD = 4'd7, S_WAIT = 4'd8, S_CHK_TIME = 4'd9, S_CHK_SEQ = 4'd10,
    S_SUM = 4'd11, S_MAP2 = 4'd12;

  logic [3:0]  state;
  logic [8:0]  buffer_limit;
  logic        rtx_mode;
  logic [6:0]  rtx_payload_type;
  logic [31:0] rtx_ssrc;
  logic        swap_original_seq;
  logic [19:0] holdoff_time;

  logic [AW-1:0] oldest_slot;
  logic [FW-1:0] fill_count;
  in_item_t      item;
  logic [15:0]   start_seq;
  logic [16:0]   pos;
  // Base position of the PID, kept for the mask walk.
  logic [16:0]   pos_base;
  logic [MW-1:0] bit_idx;
  logic [15:0]   want;
  logic [48:0]  deadline;
  logic [CW-1:0] ign_cnt, sent_cnt, nf_cnt;
  logic [20:0]  bytes;

  slot_t        slot_rdata;
  logic [47:0]  time_rdata;
  logic [AW-1:0] raddr;
  logic          slot_we, time_we;
  logic [AW-1:0] slot_waddr;

  // Shared arithmetic unit: one 17-bit subtractor used by the S_MAP and S_MAP2 steps.
  logic [16:0] alu_a, alu_b, alu_diff;
  assign alu_diff = alu_a - alu_b;

  logic [FW-1:0] lim_eff;
  always_comb begin
    if (buffer_limit == 9'd0) begin
      lim_eff = FW'(1);
    end else if ({{(32-9){1'b0}}, buffer_limit} > RING_DEPTH) begin
      lim_eff = FW'(RING_DEPTH);
    end else begin
      lim_eff = FW'(buffer_limit);
    end
  end

  logic drop;
  assign drop = (fill_count >= lim_eff) && (fill_count != '0);

  logic [AW-1:0] oldest_after;
  assign oldest_after = drop ? oldest_slot + AW'(1) : oldest_slot;

  logic [FW-1:0] fill_after;
  assign fill_after = drop ? fill_count - FW'(1) : fill_count;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [16:0] p);
    begin
      phys = base + p[AW-1:0];
    end
  endfunction

  // A visited slot is resent when it is past its hold-off and its sequence matches.
  logic hit;
  assign hit = (state == S_CHK_SEQ) && (deadline < {1'b0, item.current_time}) &&
               (slot_rdata.seq == want);

  assign slot_we    = (state == S_STORE);
  assign time_we    = slot_we || hit;
  assign slot_waddr = (state == S_STORE) ? phys(oldest_slot, 17'(fill_count)) :
                      raddr;

  logic [47:0] time_wdata;
  assign time_wdata = item.current_time;

  slot_t slot_wdata;
  assign slot_wdata = '{seq: item.sequence_number, pt: item.payload_type,
                        ts: item.rtp_timestamp, src: item.source_id,
                        marker: item.marker_bit, len: item.packet_length};

  rnrb_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
    .clk(clk), .slot_we(slot_we), .slot_waddr(slot_waddr),
    .slot_wdata(slot_wdata), .time_we(time_we), .time_waddr(slot_waddr),
    .time_wdata(time_wdata), .raddr(raddr), .slot_rdata(slot_rdata),
    .time_rdata(time_rdata)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_MAP: begin
        alu_a = {1'b0, item.sequence_number};
        alu_b = {1'b0, start_seq};
      end
      S_MAP2: begin
        alu_a = {1'b0, slot_rdata.seq};
        alu_b = {1'b0, item.sequence_number};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  logic [15:0] len_out;
  assign len_out = rtx_mode ? slot_rdata.len + 16'd2 : slot_rdata.len;

  out_item_t retx_item, sum_item;
  always_comb begin
    retx_item = '0;
    retx_item.out_timestamp = slot_rdata.ts;
    retx_item.out_marker = slot_rdata.marker;
    retx_item.out_length = len_out;
    if (rtx_mode) begin
      retx_item.out_payload_type = rtx_payload_type;
      retx_item.out_ssrc = rtx_ssrc;
      retx_item.original_seq_prefix = swap_original_seq ? slot_rdata.seq :
        {slot_rdata.seq[7:0], slot_rdata.seq[15:8]};
    end else begin
      retx_item.out_sequence = slot_rdata.seq;
      retx_item.out_payload_type = slot_rdata.pt;
      retx_item.out_ssrc = slot_rdata.src;
    end
  end

  always_comb begin
    sum_item = '0;
    sum_item.last_item = 1'b1;
    sum_item.ignored_count = ign_cnt;
    sum_item.sent_count = sent_cnt;
    sum_item.not_found_count = nf_cnt;
    sum_item.bytes_sent = bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      buffer_limit <= 9'd256;
      rtx_mode <= 1'b0;
      rtx_payload_type <= '0;
      rtx_ssrc <= '0;
      swap_original_seq <= 1'b1;
      holdoff_time <= 20'd100;
      oldest_slot <= '0;
      fill_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= hit || (state == S_SUM);
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT:    buffer_limit <= cfg_data[8:0];
          CFG_RTX:      rtx_mode <= cfg_data[0];
          CFG_RTX_PT:   rtx_payload_type <= cfg_data[6:0];
          CFG_RTX_SSRC: rtx_ssrc <= cfg_data;
          CFG_SWAP:     swap_original_seq <= cfg_data[0];
          CFG_HOLDOFF:  holdoff_time <= cfg_data[19:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          bit_idx <= '0;
          if (start) begin
            item <= in_item;
            ign_cnt <= '0;
            sent_cnt <= '0;
            nf_cnt <= '0;
            bytes <= '0;
            if (in_item.opcode == OP_STORE) begin
              state <= S_STORE;
            end else if (fill_count == '0) begin
              state <= S_SUM;
            end else begin
              state <= S_RD_START;
            end
          end
        end
        S_STORE: begin
          // The write address oldest + fill is the same before and after a drop.
          oldest_slot <= oldest_after;
          fill_count <= fill_after + FW'(1);
          state <= S_IDLE;
        end
        S_RD_START: begin
          raddr <= phys(oldest_slot, 17'd0);
          state <= S_RD_END;
        end
        S_RD_END: begin
          raddr <= phys(oldest_slot, 17'(fill_count - FW'(1)));
          state <= S_WAIT_END;
        end
        S_WAIT_END: begin
          start_seq <= slot_rdata.seq;
          state <= S_MAP;
        end
        S_MAP: begin
          // slot_rdata now holds the newest sequence.
          if (item.sequence_number >= start_seq) begin
            pos <= {1'b0, alu_diff[15:0]};
            state <= S_RD;
          end else begin
            state <= S_MAP2;
          end
        end
        S_MAP2: begin
          if (item.sequence_number <= slot_rdata.seq) begin
            if (alu_diff < 17'(fill_count)) begin
              pos <= 17'(fill_count) - alu_diff - 17'd1;
            end else begin
              pos <= alu_diff;
            end
          end else begin
            pos <= '0;
          end
          state <= S_RD;
        end
        S_RD: begin
          // Visit pos with expected sequence want, if in range.
          pos_base <= pos;
          if (pos < 17'(fill_count)) begin
            raddr <= phys(oldest_slot, pos);
            state <= S_WAIT;
          end else begin
            state <= S_NEXT;
          end
          want <= item.sequence_number;
        end
        S_WAIT: begin
          deadline <= 49'(holdoff_time);
          state <= S_CHK_TIME;
        end
        S_CHK_TIME: begin
          deadline <= deadline + {1'b0, time_rdata};
          state <= S_CHK_SEQ;
        end
        S_CHK_SEQ: begin
          if (!(deadline < {1'b0, item.current_time})) begin
            ign_cnt <= ign_cnt + CW'(1);
          end else if (slot_rdata.seq != want) begin
            nf_cnt <= nf_cnt + CW'(1);
          end else begin
            result <= retx_item;
            bytes <= bytes + 21'(len_out);
            sent_cnt <= sent_cnt + CW'(1);
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          // Advance to the next flagged mask bit, one bit per cycle while no slot is being visited.
          if (bit_idx == MW'(MASK_BITS)) begin
            state <= S_SUM;
          end else begin
            bit_idx <= bit_idx + MW'(1);
            if (item.loss_bitmask[bit_idx[BW-1:0]]) begin
              pos <= pos_base + 17'(bit_idx) + 17'd1;
              want <= item.sequence_number + 16'(bit_idx) + 16'd1;
              if (pos_base + 17'(bit_idx) + 17'd1 < 17'(fill_count)) begin
                raddr <= phys(oldest_slot, pos_base + 17'(bit_idx) + 17'd1);
                state <= S_WAIT;
              end
            end
          end
        end
        S_SUM: begin
          result <= sum_item;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
